>>> rtl/core/kbd_pkg.sv
// Package for the scan code set 1 translator: result types, key codes,
// character table and the special-key lookup functions. No dependencies.
`timescale 1ns / 1ps

package kbd_pkg;

  // Escape byte that opens a special-key pair, and fixed output bytes
  localparam logic [7:0] EscPrefix   = 8'd17;
  localparam logic [7:0] LineFeed    = 8'd10;
  localparam logic [7:0] NTildeLower = 8'd164;
  localparam logic [7:0] NTildeUpper = 8'd165;
  localparam logic [7:0] CaseOffset  = 8'd32;
  localparam logic [7:0] LowerA      = 8'd97;
  localparam logic [7:0] LowerZ      = 8'd122;

  // Scan codes with their own handling
  localparam logic [7:0] ScEmpty       = 8'd0;
  localparam logic [7:0] ScExtPrefix   = 8'd224;
  localparam logic [7:0] ScEnter       = 8'd28;
  localparam logic [7:0] ScLShiftMake  = 8'd42;
  localparam logic [7:0] ScRShiftMake  = 8'd54;
  localparam logic [7:0] ScLShiftBreak = 8'd170;
  localparam logic [7:0] ScRShiftBreak = 8'd182;
  localparam logic [7:0] ScCapsLock    = 8'd58;
  localparam logic [7:0] ScNTilde      = 8'd39;

  // Character table: entries past the filled part read as zero
  localparam int unsigned CharTableDepth = 128;
  localparam int unsigned RomFilled      = 60;

  localparam logic [7:0] CharRom [0:RomFilled-1] = '{
    8'd0,   8'd27,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,  8'd56,
    8'd57,  8'd48,  8'd39,  8'd0,   8'd8,   8'd9,   8'd113, 8'd119, 8'd101, 8'd114,
    8'd116, 8'd121, 8'd117, 8'd105, 8'd111, 8'd112, 8'd0,   8'd0,   8'd10,  8'd0,
    8'd97,  8'd115, 8'd100, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108, 8'd164,
    8'd48,  8'd48,  8'd48,  8'd48,  8'd122, 8'd120, 8'd99,  8'd118, 8'd98,  8'd110,
    8'd109, 8'd109, 8'd109, 8'd109, 8'd109, 8'd109, 8'd109, 8'd32,  8'd0,   8'd109
  };

  // Decoded result of one scan byte: zero, one or two output bytes
  typedef struct packed {
    logic [1:0] num;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } kbd_dec_t;

  // One entry of the output queue
  typedef struct packed {
    logic [7:0] key_byte;
    logic       last_byte;
  } kbd_entry_t;

  // Index is below the filled part here, so its low six bits address the table
  function automatic logic [7:0] rom_read(input logic [7:0] idx);
    logic [7:0] b;
    b = 8'd0;
    if (32'(idx) < CharTableDepth && 32'(idx) < RomFilled) begin
      b = CharRom[idx[5:0]];
    end
    return b;
  endfunction

  // Special key code after an E0 prefix, zero if none
  function automatic logic [7:0] ext_special(input logic [7:0] c);
    logic [7:0] k;
    unique case (c)
      8'd82:   k = 8'd15;
      8'd83:   k = 8'd16;
      8'd29:   k = 8'd24;
      8'd157:  k = 8'd25;
      8'd72:   k = 8'd20;
      8'd80:   k = 8'd21;
      8'd75:   k = 8'd23;
      8'd77:   k = 8'd22;
      8'd71:   k = 8'd30;
      8'd79:   k = 8'd31;
      8'd73:   k = 8'd32;
      8'd81:   k = 8'd33;
      default: k = 8'd0;
    endcase
    return k;
  endfunction

  // Special key code for a plain byte, zero if none; F1..F10 map in a run
  function automatic logic [7:0] plain_special(input logic [7:0] c);
    logic [7:0] k;
    if (c >= 8'd59 && c <= 8'd68) begin
      k = c - 8'd57;
    end else begin
      unique case (c)
        8'd1:    k = 8'd1;
        8'd87:   k = 8'd12;
        8'd88:   k = 8'd13;
        8'd14:   k = 8'd17;
        8'd15:   k = 8'd18;
        8'd29:   k = 8'd24;
        8'd157:  k = 8'd25;
        8'd56:   k = 8'd26;
        8'd184:  k = 8'd27;
        default: k = 8'd0;
      endcase
    end
    return k;
  endfunction

endpackage

>>> rtl/core/kbd_if.sv
// Handshake channels of the translator: scan byte in, key byte out.
// Depends on nothing.
`timescale 1ns / 1ps

interface kbd_scan_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_code;

  modport source (output valid, output scan_code, input ready);
  modport sink   (input valid, input scan_code, output ready);
endinterface

interface kbd_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  logic       last_byte;

  modport source (output valid, output key_byte, output last_byte, input ready);
  modport sink   (input valid, input key_byte, input last_byte, output ready);
endinterface

>>> rtl/core/kbd_decode.sv
// Decoder stage: keeps the prefix, shift and caps lock flags and turns one
// registered scan byte into zero, one or two output bytes. Uses kbd_pkg.
`timescale 1ns / 1ps

module kbd_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       scan_code_i,
  input  logic             fire_i,
  output kbd_pkg::kbd_dec_t res_o
);
  import kbd_pkg::*;

  logic ext_q, ext_d;
  logic shift_q, shift_d;
  logic caps_q, caps_d;

  logic       upper;
  logic [7:0] sp_ext;
  logic [7:0] sp_plain;
  logic [7:0] rom_b;

  assign upper    = shift_q | caps_q;
  assign sp_ext   = ext_special(scan_code_i);
  assign sp_plain = plain_special(scan_code_i);
  assign rom_b    = rom_read(scan_code_i);

  // Translation and flag update, in priority order
  always_comb begin
    ext_d       = ext_q;
    shift_d     = shift_q;
    caps_d      = caps_q;
    res_o.num   = 2'd0;
    res_o.byte0 = EscPrefix;
    res_o.byte1 = 8'd0;
    priority if (scan_code_i == ScEmpty) begin
      // empty byte: no output, flags untouched
    end else if (ext_q) begin
      ext_d = 1'b0;
      if (sp_ext != 8'd0) begin
        res_o.num   = 2'd2;
        res_o.byte1 = sp_ext;
      end
    end else if (scan_code_i == ScExtPrefix) begin
      ext_d = 1'b1;
    end else if (sp_plain != 8'd0) begin
      res_o.num   = 2'd2;
      res_o.byte1 = sp_plain;
    end else if (scan_code_i == ScEnter) begin
      res_o.num   = 2'd1;
      res_o.byte0 = LineFeed;
    end else if (scan_code_i == ScLShiftMake || scan_code_i == ScRShiftMake) begin
      shift_d = 1'b1;
    end else if (scan_code_i == ScLShiftBreak || scan_code_i == ScRShiftBreak) begin
      shift_d = 1'b0;
    end else if (scan_code_i == ScCapsLock) begin
      caps_d = ~caps_q;
    end else if (scan_code_i == ScNTilde) begin
      res_o.num   = 2'd1;
      res_o.byte0 = upper ? NTildeUpper : NTildeLower;
    end else if (!scan_code_i[7]) begin
      res_o.num   = 2'd1;
      res_o.byte0 = (upper && rom_b >= LowerA && rom_b <= LowerZ) ? rom_b - CaseOffset
                                                                  : rom_b;
    end else begin
      // other break codes: nothing
    end
  end

  // Flags advance only when the byte is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q   <= 1'b0;
      shift_q <= 1'b0;
      caps_q  <= 1'b0;
    end else if (fire_i) begin
      ext_q   <= ext_d;
      shift_q <= shift_d;
      caps_q  <= caps_d;
    end
  end

  // A pair always opens with the escape byte
  a_pair_esc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.num == 2'd2) |-> (res_o.byte0 == EscPrefix && res_o.byte1 != 8'd0))
    else $error("special pair without escape byte or key code");

  // A plain prefix byte sets the prefix flag
  a_ext_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !ext_q && scan_code_i == ScExtPrefix) |=> ext_q)
    else $error("extended prefix not recorded");

  // An empty byte never changes a flag
  a_empty_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && scan_code_i == ScEmpty) |=> ($stable(ext_q) && $stable(shift_q) &&
                                          $stable(caps_q)))
    else $error("empty byte changed decoder flags");

endmodule

>>> rtl/core/kbd_out_fifo.sv
// Result queue of four entries: takes up to two bytes per cycle from the
// decoder and hands out one per cycle while pop_i is high. Uses kbd_pkg.
`timescale 1ns / 1ps

module kbd_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  kbd_pkg::kbd_dec_t   res_i,
  input  logic                pop_i,
  output logic                room_o,
  output logic                valid_o,
  output kbd_pkg::kbd_entry_t head_o
);
  import kbd_pkg::*;

  kbd_entry_t mem_q [4];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] push_num;
  logic       pop;

  assign push_num = push_i ? res_i.num : 2'd0;
  assign pop      = pop_i && valid_o;
  assign valid_o  = cnt_q != 3'd0;
  assign head_o   = mem_q[rd_q];
  // Room for a full pair once this cycle's pop is counted
  assign room_o   = (cnt_q < 3'd3) || (cnt_q == 3'd3 && pop);

  // Pointer and count update
  always_comb begin
    wr_d  = wr_q + push_num;
    rd_d  = rd_q + {1'b0, pop};
    cnt_d = cnt_q + {1'b0, push_num} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry writes: first byte is last only for a single result
  always_ff @(posedge clk_i) begin
    if (push_num != 2'd0) begin
      mem_q[wr_q] <= '{key_byte: res_i.byte0, last_byte: (push_num == 2'd1)};
    end
    if (push_num == 2'd2) begin
      mem_q[wr_q + 2'd1] <= '{key_byte: res_i.byte1, last_byte: 1'b1};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_num == 2'd2) |-> (cnt_q - {2'b00, pop} <= 3'd2))
    else $error("pair pushed without room");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_num == 2'd0) |=> (cnt_q == $past(cnt_q) - 3'd1))
    else $error("queue count did not drop on pop");

endmodule

>>> rtl/core/keyboard_scan_code_translator.sv
// Top level of the scan code set 1 translator: input register, decoder and
// result queue. Uses kbd_pkg, kbd_if, kbd_decode and kbd_out_fifo.
`timescale 1ns / 1ps

// Scan code set 1 translator. Each accepted scan byte yields zero, one or
// two key bytes; a special key comes out as escape byte 17 then its code,
// and the last byte of each scan byte carries last_byte high. A scan byte
// is registered on acceptance and decoded in the next cycle, and the
// result enters the queue once it has room. Scan bytes that give zero or
// one key byte are taken one per cycle while the queue has room; the key
// channel moves one item per cycle while ready is high, so a pair leaves
// byte by byte, and a four-entry result queue decouples the two channels.
module keyboard_scan_code_translator (
  input  logic clk_i,
  input  logic rst_ni,
  kbd_scan_if.sink  scan_i,
  kbd_key_if.source key_o
);
  import kbd_pkg::*;

  logic       s1_valid_q;
  logic [7:0] s1_scan_q;
  logic       s1_fire;
  logic       room;
  kbd_dec_t   dec;
  kbd_entry_t head;

  assign s1_fire      = s1_valid_q && room;
  assign scan_i.ready = !s1_valid_q || room;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (scan_i.ready) begin
      s1_valid_q <= scan_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_i.ready && scan_i.valid) begin
      s1_scan_q <= scan_i.scan_code;
    end
  end

  kbd_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .scan_code_i(s1_scan_q),
    .fire_i     (s1_fire),
    .res_o      (dec)
  );

  kbd_out_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s1_fire),
    .res_i  (dec),
    .pop_i  (key_o.ready),
    .room_o (room),
    .valid_o(key_o.valid),
    .head_o (head)
  );

  assign key_o.key_byte  = head.key_byte;
  assign key_o.last_byte = head.last_byte;

  // A held input byte is not lost while the queue is full
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !room) |=> (s1_valid_q && $stable(s1_scan_q)))
    else $error("stalled scan byte dropped");

  // Input is refused only while a byte waits for queue room
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !scan_i.ready |-> (s1_valid_q && !room))
    else $error("input stalled without cause");

  // Decode fires only while a byte is held
  a_fire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |-> s1_valid_q)
    else $error("decode fired without a byte");

endmodule
